// ----- rtl/modexp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg: shared constants and types for the modular exponentiation block
// Holds the default word width, the register index codes and the status
// group that a modular multiplier reports back to the sequencer.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int WORD_BITS_DEF = 31;

  // configuration index field width: wide enough to see writes past the list
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

// ----- rtl/modexp_mulmod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_mulmod: bit-serial modular multiplier
// Computes (a * b) mod m by interleaved shift-and-add, taking the multiplier
// from its top bit down, each bit in a double step and then an add step.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
  parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] op_a,
  input  logic [WORD_BITS-1:0] op_b,
  input  logic [WORD_BITS-1:0] op_m,
  output logic [WORD_BITS-1:0] result,
  output modexp_pkg::mm_stat_t stat
);
  import modexp_pkg::*;

  localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(WORD_BITS - 1);

  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] a_r;
  logic [WORD_BITS-1:0] m_r;
  logic [WORD_BITS-1:0] bsh_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 phase_r;
  logic                 busy_r;
  logic                 done_r;

  logic [WORD_BITS-1:0] addend;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   diff;

  // phase 0 doubles the accumulator, phase 1 adds a when the multiplier bit is set
  always_comb begin
    if (!phase_r) begin
      addend = acc_r;
    end else if (bsh_r[WORD_BITS-1]) begin
      addend = a_r;
    end else begin
      addend = '0;
    end
    sum  = {1'b0, acc_r} + {1'b0, addend};
    diff = sum - {1'b0, m_r};
    acc_nxt = (sum >= {1'b0, m_r}) ? diff[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
        cnt_r   <= '0;
      end else if (busy_r) begin
        phase_r <= ~phase_r;
        if (phase_r) begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_BIT) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= op_a;
      m_r   <= op_m;
      bsh_r <= op_b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      if (phase_r) begin
        bsh_r <= {bsh_r[WORD_BITS-2:0], 1'b0};
      end
    end
  end

  assign result    = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- rtl/modular_exponentiation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation: right-to-left square-and-multiply, base^e mod n
// Streams bases in and powers out; modulus and exponent are set-up registers.
// ----------------------------------------------------------------------------
// One base is worked on at a time. Each beat on the input stream yields one
// beat on the output stream carrying base^exponent mod modulus, always fully
// reduced (a modulus of one, or zero, gives zero). Every modular product runs
// through a bit-serial multiplier; the base is first reduced by one such pass,
// then each exponent bit up to the highest set one costs one pass in which the
// multiply and the square run side by side in two multipliers. The block is
// ready for the next base in the same cycle that the power is presented.
// The output register lets a new base be accepted while the last power still
// waits to be taken; the new power then holds in the last step until the old
// one has gone. Write modulus and exponent only while the block is idle.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream, tdata: base [WORD_BITS-1:0], zero padding above
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((WORD_BITS+7)/8)*8-1:0]      in_tdata,
  // output stream, tdata: power [WORD_BITS-1:0], zero padding above
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((WORD_BITS+7)/8)*8-1:0]      out_tdata,
  // configuration writes: index 0 modulus, index 1 exponent
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [modexp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]                cfg_data
);
  import modexp_pkg::*;

  localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RED   = 5'b00010,
    S_ISSUE = 5'b00100,
    S_MUL   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [WORD_BITS-1:0] modulus_r;
  logic [WORD_BITS-1:0] exponent_r;

  logic [WORD_BITS-1:0] m_r;
  logic [WORD_BITS-1:0] e_r;
  logic [WORD_BITS-1:0] acc_r;
  logic [WORD_BITS-1:0] b_r;
  logic [WORD_BITS-1:0] out_data_r;
  logic                 out_valid_r;

  logic [WORD_BITS-1:0] m_eff;
  logic [WORD_BITS-1:0] one_mod;
  logic [WORD_BITS-1:0] e_shift;
  logic                 in_beat;
  logic                 out_free;

  logic                 start_a, start_b;
  logic [WORD_BITS-1:0] mul_a_op_a, mul_a_op_b, mul_a_op_m;
  logic [WORD_BITS-1:0] res_a, res_b;
  mm_stat_t             stat_a, stat_b;

  // a modulus of zero behaves as one; one reduced by the modulus seeds acc
  assign m_eff   = (modulus_r == '0) ? WORD_BITS'(1) : modulus_r;
  assign one_mod = (m_eff == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
  assign e_shift = e_r >> 1;

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // ---- configuration registers ---------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= WORD_BITS'(1);
      exponent_r <= WORD_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODULUS:  modulus_r  <= cfg_data;
        REG_EXPONENT: exponent_r <= cfg_data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---- multipliers -----------------------------------------------------------
  // Unit A reduces the base on accept (one times base, mod n), then forms acc*b.
  // Unit B forms b*b in step with it.
  assign start_a = in_beat || (state_r == S_ISSUE);
  assign start_b = (state_r == S_ISSUE);

  always_comb begin
    if (state_r == S_IDLE) begin
      mul_a_op_a = one_mod;
      mul_a_op_b = in_tdata[WORD_BITS-1:0];
      mul_a_op_m = m_eff;
    end else begin
      mul_a_op_a = acc_r;
      mul_a_op_b = b_r;
      mul_a_op_m = m_r;
    end
  end

  modexp_mulmod #(
    .WORD_BITS (WORD_BITS)
  ) u_mul_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_a),
    .op_a   (mul_a_op_a),
    .op_b   (mul_a_op_b),
    .op_m   (mul_a_op_m),
    .result (res_a),
    .stat   (stat_a)
  );

  modexp_mulmod #(
    .WORD_BITS (WORD_BITS)
  ) u_mul_sqr (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_b),
    .op_a   (b_r),
    .op_b   (b_r),
    .op_m   (m_r),
    .result (res_b),
    .stat   (stat_b)
  );

  // ---- sequencer -------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat) state_nxt = S_RED;
      end
      S_RED: begin
        // an exponent of zero leaves acc at one mod n
        if (stat_a.done) state_nxt = (e_r == '0) ? S_OUT : S_ISSUE;
      end
      S_ISSUE: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (stat_a.done) state_nxt = (e_shift == '0) ? S_OUT : S_ISSUE;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers: latch key on accept, advance one exponent bit per pass
  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_r   <= m_eff;
      e_r   <= exponent_r;
      acc_r <= one_mod;
    end
    if (state_r == S_RED && stat_a.done) begin
      b_r <= res_a;
    end
    if (state_r == S_MUL && stat_a.done) begin
      if (e_r[0]) acc_r <= res_a;
      b_r <= res_b;
      e_r <= e_shift;
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= acc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_BITS'(out_data_r);

  // ---- assertions ------------------------------------------------------------
  a_units_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (stat_a.done == stat_b.done))
    else $error("multiply and square units out of step");

  a_idle_units_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!stat_a.busy && !stat_b.busy))
    else $error("input taken while a multiplier is busy");

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (acc_r < m_r))
    else $error("accumulator not reduced");

  a_accept_reduces: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == S_RED && stat_a.busy))
    else $error("base reduction not started on accept");

  a_output_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_valid_r && out_data_r < m_r))
    else $error("result not reduced or not presented");

endmodule
